// ===== design/hs_pkg.sv =====
// Shared word types for the heap sorter unit and its sorting cells.
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

    // Width of the key field on both channels.
    localparam int unsigned WORD_KEY_WIDTH = 32;

    // Input word: one key and the end-of-set mark.
    typedef struct packed {
        logic [WORD_KEY_WIDTH-1:0] key;
        logic                      last;
    } in_word_t;

    // Result word: one sorted key with its run flags.
    typedef struct packed {
        logic [WORD_KEY_WIDTH-1:0] sorted_key;
        logic                      last_out;
        logic                      overflow;
    } out_word_t;

    // Operation that every cell of the chain performs in a cycle.
    typedef struct packed {
        logic insert;
        logic shift_dn;
        logic shift_up;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/hs_cell.sv =====
// One cell of the sorted chain: holds one key and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module hs_cell #(
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire hs_pkg::cell_ctrl_t  ctrl,
    input  wire  [KEY_WIDTH-1:0]     new_key,
    input  wire  [KEY_WIDTH-1:0]     lo_key,
    input  wire                      lo_valid,
    input  wire                      lo_gt,
    input  wire  [KEY_WIDTH-1:0]     hi_key,
    input  wire                      hi_valid,
    output logic [KEY_WIDTH-1:0]     cell_key,
    output logic                     cell_valid,
    output logic                     cell_gt
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;

    // An empty cell counts as larger than any key, so empty cells stay on top.
    assign cell_gt    = !valid_reg || (key_reg > new_key);
    assign cell_key   = key_reg;
    assign cell_valid = valid_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (cell_gt)
            begin
                if (!lo_gt)
                begin
                    key_next   = new_key;
                    valid_next = 1'b1;
                end
                else
                begin
                    key_next   = lo_key;
                    valid_next = lo_valid;
                end
            end
        end
        else if (ctrl.shift_dn)
        begin
            key_next   = hi_key;
            valid_next = hi_valid;
        end
        else if (ctrl.shift_up)
        begin
            key_next   = lo_key;
            valid_next = lo_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== design/heap_sorter_unit.sv =====
// Top level of the heap sorter unit: control, output register and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// key       in         key_valid/key_stall   key_word (hs_pkg::in_word_t)
// result    out        result_valid/stall    result_word (hs_pkg::out_word_t)
// config    in         sort_order_we         sort_order_wdata (1 bit)
//
// Keys load at one word per cycle while the unit is in its load phase.
// After the word marked last, an ascending run goes straight to emitting its
// n words; a descending run first moves the chain to its top end until the
// top cell is filled, and then emits n words.
// Reset clears the valid bits of all cells, the key count and the drop flag;
// sort_order comes out of reset as 1. No clearing pass is needed.
// A stall on the result channel holds the emit sequence in place; key_stall
// is high for the whole sort and emit phase.

module heap_sorter_unit #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    key_valid,
    output logic                   key_stall,
    input  wire hs_pkg::in_word_t  key_word,
    output logic                   result_valid,
    input  wire                    result_stall,
    output hs_pkg::out_word_t      result_word,
    input  wire                    sort_order_we,
    input  wire                    sort_order_wdata
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_COUNT = CW'(1);

    // One-hot phase of the unit.
    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ALIGN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              drop_reg;
    logic              drop_next;
    logic              desc_reg;
    logic              desc_next;
    logic              sort_order_reg;
    logic              out_valid_reg;
    hs_pkg::out_word_t out_word_reg;

    logic              accept_in;
    logic              has_room;
    logic              take_ok;
    logic              emit;
    logic [KEY_WIDTH-1:0] new_key;
    hs_pkg::cell_ctrl_t   ctrl;

    // Chain wires, one entry per cell.
    logic [KEY_WIDTH-1:0] key_w    [CAPACITY];
    logic [CAPACITY-1:0]  vld_w;
    logic [CAPACITY-1:0]  gt_w;
    logic [KEY_WIDTH-1:0] lo_key_w [CAPACITY];
    logic [CAPACITY-1:0]  lo_vld_w;
    logic [CAPACITY-1:0]  lo_gt_w;
    logic [KEY_WIDTH-1:0] hi_key_w [CAPACITY];
    logic [CAPACITY-1:0]  hi_vld_w;

    // The chain is kept in ascending order with its filled cells packed at
    // cell 0. Ascending runs emit from cell 0, descending runs from the top cell.
    assign key_stall = (state_reg != ST_LOAD);
    assign accept_in = key_valid && !key_stall;
    assign has_room  = (count_reg < CAP_COUNT);
    assign take_ok   = !out_valid_reg || !result_stall;
    assign emit      = (state_reg == ST_EMIT) && take_ok;
    assign new_key   = KEY_WIDTH'(key_word.key);

    assign ctrl.insert   = accept_in && has_room;
    assign ctrl.shift_dn = emit && !desc_reg;
    assign ctrl.shift_up = (emit && desc_reg)
                        || ((state_reg == ST_ALIGN) && !vld_w[CAPACITY-1]);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_bottom
                assign lo_key_w[gi] = '0;
                assign lo_vld_w[gi] = 1'b0;
                assign lo_gt_w[gi]  = 1'b0;
            end
            else
            begin : g_lower
                assign lo_key_w[gi] = key_w[gi-1];
                assign lo_vld_w[gi] = vld_w[gi-1];
                assign lo_gt_w[gi]  = gt_w[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_top
                assign hi_key_w[gi] = '0;
                assign hi_vld_w[gi] = 1'b0;
            end
            else
            begin : g_upper
                assign hi_key_w[gi] = key_w[gi+1];
                assign hi_vld_w[gi] = vld_w[gi+1];
            end
            hs_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .lo_key     (lo_key_w[gi]),
                .lo_valid   (lo_vld_w[gi]),
                .lo_gt      (lo_gt_w[gi]),
                .hi_key     (hi_key_w[gi]),
                .hi_valid   (hi_vld_w[gi]),
                .cell_key   (key_w[gi]),
                .cell_valid (vld_w[gi]),
                .cell_gt    (gt_w[gi])
            );
        end
    endgenerate

    // Phase control. The key count doubles as the emit countdown, and the
    // sort direction is captured when the last word of a set arrives.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        desc_next  = desc_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept_in)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + ONE_COUNT;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (key_word.last)
                    begin
                        desc_next  = !sort_order_reg;
                        state_next = sort_order_reg ? ST_EMIT : ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (vld_w[CAPACITY-1])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    count_next = count_reg - ONE_COUNT;
                    if (count_reg == ONE_COUNT)
                    begin
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            desc_reg       <= 1'b0;
            sort_order_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            desc_reg  <= desc_next;
            if (sort_order_we)
            begin
                sort_order_reg <= sort_order_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register: the end cell of the chain for this run's direction.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg.sorted_key <= desc_reg
                ? hs_pkg::WORD_KEY_WIDTH'(key_w[CAPACITY-1])
                : hs_pkg::WORD_KEY_WIDTH'(key_w[0]);
            out_word_reg.last_out   <= (count_reg == ONE_COUNT);
            out_word_reg.overflow   <= drop_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // The key count never passes the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("key count exceeds capacity");

    // While loading, the filled cells match the key count.
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (CW'($countones(vld_w)) == count_reg))
        else $error("filled cells disagree with key count");

    // Every emitted word comes from a filled end cell.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (desc_reg ? vld_w[CAPACITY-1] : vld_w[0]))
        else $error("emit from an empty end cell");

    // A key that meets a full chain raises the drop flag.
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && !has_room) |=> drop_reg)
        else $error("dropped key not flagged");

endmodule

`default_nettype wire
